@@ sv/bqlp_pkg.sv @@
// Shared types, constants and tables for the biquad low-pass coefficient generator.
package bqlp_pkg;

   localparam int FREQ_W          = 18;
   localparam int Q_W             = 16;
   localparam int COEF_W          = 32;
   localparam int PHASE_W         = 32;
   localparam int DIV_W           = FREQ_W + PHASE_W;   // phase dividend width
   localparam int CORDIC_W        = 34;
   localparam int MAG_W           = 31;
   localparam int ALPHA_W         = MAG_W + 8;          // alpha dividend width
   localparam int ATAN_LEN        = 32;
   localparam int ROT_STAGES_DEF  = 24;
   localparam int COEF_FRAC_DEF   = 28;
   localparam logic [FREQ_W-1:0] FS_RESET = FREQ_W'(44100);
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

   // Arctangent of 2^-i in turns, scaled by 2^32
   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic [FREQ_W-1:0] cutoff_hz;
      logic [Q_W-1:0]    quality;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_b0;
      logic signed [COEF_W-1:0] coef_b1;
      logic signed [COEF_W-1:0] coef_b2;
      logic signed [COEF_W-1:0] coef_a0;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
   } rsp_type;

endpackage

@@ sv/biquad_lowpass_coefficients.sv @@
// Biquad low-pass coefficient generator: pipelined phase divider, CORDIC and alpha divider.
//
// One transaction enters every clock cycle; busy is high only during reset. Each request
// yields exactly one result strobed on rsp_valid. The path through the block is made of a
// 50-stage one-bit-per-stage phase divider, the CORDIC stages, a 39-stage one-bit-per-stage
// alpha divider, and input, preparation and output registers. The result cannot be held
// off by the receiver. The sample rate register is written through csr_* (always ready)
// and must only change while no transaction is in flight.
module biquad_lowpass_coefficients #(
   parameter int ROT_STAGES     = bqlp_pkg::ROT_STAGES_DEF,
   parameter int COEF_FRAC_BITS = bqlp_pkg::COEF_FRAC_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bqlp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output bqlp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bqlp_pkg::FREQ_W-1:0]       csr_data
);
   import bqlp_pkg::*;

   localparam int SH = 30 - COEF_FRAC_BITS;

   // Round half up by s bits, then saturate to 32 signed bits
   function automatic logic signed [COEF_W-1:0] rnd_sat(input logic signed [47:0] v,
                                                         input int s);
      logic signed [47:0] half;
      logic signed [47:0] r;
      half = (48'sd1 <<< s) >>> 1;
      r    = (v + half) >>> s;
      if (r > 48'sd2147483647)
         return 32'sh7FFFFFFF;
      else if (r < -48'sd2147483648)
         return 32'sh80000000;
      else
         return r[COEF_W-1:0];
   endfunction

   logic accept;
   logic [FREQ_W-1:0] fs_ff;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Sample rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= FS_RESET;
      end else if (csr_valid && csr_ready) begin
         fs_ff <= csr_data;
      end
   end

   // ---------------- phase divider: (f*2^32 + fs/2) / fs, low 32 quotient bits
   logic                 pd_vld_ff [DIV_W+1];
   logic [FREQ_W-1:0]    pd_rem_ff [DIV_W+1];
   logic [DIV_W-1:0]     pd_num_ff [DIV_W+1];
   logic [PHASE_W-1:0]   pd_quo_ff [DIV_W+1];
   logic [Q_W-1:0]       pd_q_ff   [DIV_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pd_vld_ff[0] <= 1'b0;
      end else begin
         pd_vld_ff[0] <= accept;
      end
      pd_rem_ff[0] <= '0;
      pd_num_ff[0] <= {req_data.cutoff_hz, PHASE_W'(fs_ff >> 1)};
      pd_quo_ff[0] <= '0;
      pd_q_ff[0]   <= req_data.quality;
   end

   for (genvar k = 0; k < DIV_W; k++) begin : g_pdiv
      logic [FREQ_W:0] trial;
      logic [FREQ_W:0] diff;
      logic            ge;
      assign trial = {pd_rem_ff[k], pd_num_ff[k][DIV_W-1]};
      assign diff  = trial - {1'b0, fs_ff};
      assign ge    = (trial >= {1'b0, fs_ff});
      always_ff @(posedge clock) begin
         if (reset) begin
            pd_vld_ff[k+1] <= 1'b0;
         end else begin
            pd_vld_ff[k+1] <= pd_vld_ff[k];
         end
         pd_rem_ff[k+1] <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
         pd_num_ff[k+1] <= pd_num_ff[k] << 1;
         pd_quo_ff[k+1] <= {pd_quo_ff[k][PHASE_W-2:0], ge};
         pd_q_ff[k+1]   <= pd_q_ff[k];
      end
   end

   // ---------------- CORDIC
   logic                       cx_vld_ff  [ROT_STAGES+1];
   logic signed [CORDIC_W-1:0] cx_x_ff    [ROT_STAGES+1];
   logic signed [CORDIC_W-1:0] cx_y_ff    [ROT_STAGES+1];
   logic signed [CORDIC_W-1:0] cx_z_ff    [ROT_STAGES+1];
   logic                       cx_flip_ff [ROT_STAGES+1];
   logic [Q_W-1:0]             cx_q_ff    [ROT_STAGES+1];

   // Fold phase into [-1/4, 1/4) turn
   logic [PHASE_W-1:0] phase;
   logic               flip_in;
   logic [PHASE_W-1:0] phase_fold;
   assign phase      = (fs_ff == '0) ? '0 : pd_quo_ff[DIV_W];
   assign flip_in    = phase[PHASE_W-1] ^ phase[PHASE_W-2];
   assign phase_fold = {phase[PHASE_W-1] ^ flip_in, phase[PHASE_W-2:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_vld_ff[0] <= 1'b0;
      end else begin
         cx_vld_ff[0] <= pd_vld_ff[DIV_W];
      end
      cx_x_ff[0]    <= CORDIC_GAIN;
      cx_y_ff[0]    <= '0;
      cx_z_ff[0]    <= {{(CORDIC_W-PHASE_W){phase_fold[PHASE_W-1]}}, phase_fold};
      cx_flip_ff[0] <= flip_in;
      cx_q_ff[0]    <= pd_q_ff[DIV_W];
   end

   for (genvar i = 0; i < ROT_STAGES; i++) begin : g_rot
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      logic signed [CORDIC_W-1:0] ang;
      assign dx  = cx_y_ff[i] >>> i;
      assign dy  = cx_x_ff[i] >>> i;
      assign ang = signed'({{(CORDIC_W-32){1'b0}}, ATAN_TURNS[i]});
      always_ff @(posedge clock) begin
         if (reset) begin
            cx_vld_ff[i+1] <= 1'b0;
         end else begin
            cx_vld_ff[i+1] <= cx_vld_ff[i];
         end
         if (!cx_z_ff[i][CORDIC_W-1]) begin
            cx_x_ff[i+1] <= cx_x_ff[i] - dx;
            cx_y_ff[i+1] <= cx_y_ff[i] + dy;
            cx_z_ff[i+1] <= cx_z_ff[i] - ang;
         end else begin
            cx_x_ff[i+1] <= cx_x_ff[i] + dx;
            cx_y_ff[i+1] <= cx_y_ff[i] - dy;
            cx_z_ff[i+1] <= cx_z_ff[i] + ang;
         end
         cx_flip_ff[i+1] <= cx_flip_ff[i];
         cx_q_ff[i+1]    <= cx_q_ff[i];
      end
   end

   // ---------------- alpha divider: (|sin|*128 + Q/2) / Q
   logic                       ad_vld_ff [ALPHA_W+1];
   logic [Q_W-1:0]             ad_rem_ff [ALPHA_W+1];
   logic [ALPHA_W-1:0]         ad_num_ff [ALPHA_W+1];
   logic [ALPHA_W-1:0]         ad_quo_ff [ALPHA_W+1];
   logic [Q_W-1:0]             ad_q_ff   [ALPHA_W+1];
   logic signed [CORDIC_W-1:0] ad_c_ff   [ALPHA_W+1];
   logic                       ad_neg_ff [ALPHA_W+1];

   // Unfold cos/sin and form the alpha dividend
   logic signed [CORDIC_W-1:0] cos_in;
   logic signed [CORDIC_W-1:0] sin_in;
   logic signed [CORDIC_W-1:0] sin_abs;
   logic [Q_W-1:0]             q_in;
   assign cos_in  = cx_flip_ff[ROT_STAGES] ? -cx_x_ff[ROT_STAGES] : cx_x_ff[ROT_STAGES];
   assign sin_in  = cx_flip_ff[ROT_STAGES] ? -cx_y_ff[ROT_STAGES] : cx_y_ff[ROT_STAGES];
   assign sin_abs = sin_in[CORDIC_W-1] ? -sin_in : sin_in;
   assign q_in    = (cx_q_ff[ROT_STAGES] == '0) ? Q_W'(1) : cx_q_ff[ROT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         ad_vld_ff[0] <= 1'b0;
      end else begin
         ad_vld_ff[0] <= cx_vld_ff[ROT_STAGES];
      end
      ad_rem_ff[0] <= '0;
      ad_num_ff[0] <= ALPHA_W'({sin_abs[MAG_W-1:0], 7'b0}) + ALPHA_W'(q_in >> 1);
      ad_quo_ff[0] <= '0;
      ad_q_ff[0]   <= q_in;
      ad_c_ff[0]   <= cos_in;
      ad_neg_ff[0] <= sin_in[CORDIC_W-1];
   end

   for (genvar k = 0; k < ALPHA_W; k++) begin : g_adiv
      logic [Q_W:0] trial;
      logic [Q_W:0] diff;
      logic         ge;
      assign trial = {ad_rem_ff[k], ad_num_ff[k][ALPHA_W-1]};
      assign diff  = trial - {1'b0, ad_q_ff[k]};
      assign ge    = (trial >= {1'b0, ad_q_ff[k]});
      always_ff @(posedge clock) begin
         if (reset) begin
            ad_vld_ff[k+1] <= 1'b0;
         end else begin
            ad_vld_ff[k+1] <= ad_vld_ff[k];
         end
         ad_rem_ff[k+1] <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
         ad_num_ff[k+1] <= ad_num_ff[k] << 1;
         ad_quo_ff[k+1] <= {ad_quo_ff[k][ALPHA_W-2:0], ge};
         ad_q_ff[k+1]   <= ad_q_ff[k];
         ad_c_ff[k+1]   <= ad_c_ff[k];
         ad_neg_ff[k+1] <= ad_neg_ff[k];
      end
   end

   // ---------------- coefficient rounding and saturation
   logic signed [47:0] one_w;
   logic signed [47:0] cos_w;
   logic signed [47:0] mag_w;
   logic signed [47:0] alpha_w;
   logic signed [47:0] omc_w;
   rsp_type            rsp_in;
   rsp_type            rsp_data_ff;
   logic               rsp_valid_ff;

   assign one_w   = 48'sd1 <<< 30;
   assign cos_w   = 48'(ad_c_ff[ALPHA_W]);
   assign mag_w   = signed'({{(48-ALPHA_W){1'b0}}, ad_quo_ff[ALPHA_W]});
   assign alpha_w = ad_neg_ff[ALPHA_W] ? -mag_w : mag_w;
   assign omc_w   = one_w - cos_w;

   always_comb begin
      rsp_in.coef_b0 = rnd_sat(omc_w, SH + 1);
      rsp_in.coef_b1 = rnd_sat(omc_w, SH);
      rsp_in.coef_b2 = rnd_sat(omc_w, SH + 1);
      rsp_in.coef_a0 = rnd_sat(one_w + alpha_w, SH);
      rsp_in.coef_a1 = rnd_sat(-(cos_w <<< 1), SH);
      rsp_in.coef_a2 = rnd_sat(one_w - alpha_w, SH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ad_vld_ff[ALPHA_W];
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/bqlp_check.sv @@
// Port-level checker for the biquad low-pass coefficient generator, with its bind.
module bqlp_check #(
   parameter int ROT_STAGES = bqlp_pkg::ROT_STAGES_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bqlp_pkg::rsp_type rsp_data,
   input logic              rsp_valid
);
   import bqlp_pkg::*;

   localparam int LAT = DIV_W + ALPHA_W + ROT_STAGES + 4;

   // Every transaction returns exactly one result at fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("missing result after accepted transaction");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching transaction");

   // b2 is the same coefficient as b0
   a_b0_eq_b2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.coef_b0 == rsp_data.coef_b2))
      else $error("b0 and b2 differ");

   // Nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind biquad_lowpass_coefficients bqlp_check #(.ROT_STAGES(ROT_STAGES)) u_bqlp_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);
